>>> rtl/tse_pkg.sv
// Shared types, constants and the microcode program of the Taylor series evaluator.
`default_nettype none
package tse_pkg;

   localparam int FRAC_BITS = 28;
   localparam int X_W       = 30;
   localparam int Q_W       = 32;
   localparam int CMD_W     = 2;
   localparam int CSR_W     = 6;
   localparam int TIDX_W    = 5;
   localparam int RND_W     = 34;
   localparam int PROD_W    = 64;

   localparam logic [CSR_W-1:0]  NUM_TERMS_RST = 6'd20;
   localparam logic [Q_W-1:0]    ONE_Q         = 32'h1000_0000;
   localparam logic [Q_W-1:0]    Q_MAX         = 32'h7FFF_FFFF;
   localparam logic [Q_W-1:0]    Q_MIN         = 32'h8000_0000;
   localparam logic [PROD_W-1:0] HALF_Q        = 64'd1 << (FRAC_BITS - 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_SIN = 2'd0,
      CMD_COS = 2'd1,
      CMD_EXP = 2'd2,
      CMD_LN  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_X2_MUL,
      OP_X2_RND,
      OP_EMIT,
      OP_TERM_MUL,
      OP_TERM_RND,
      OP_SCALE,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_UPDATE
   } op_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_LAST,
      COND_DIV_MORE
   } cond_type;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'd0,
      ST_X2_MUL   = 4'd1,
      ST_X2_RND   = 4'd2,
      ST_EMIT     = 4'd3,
      ST_MUL      = 4'd4,
      ST_RND      = 4'd5,
      ST_SCALE    = 4'd6,
      ST_DIV_LOAD = 4'd7,
      ST_DIV      = 4'd8,
      ST_UPDATE   = 4'd9
   } step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      op_type op;
   } seq_ctrl_type;

   typedef struct packed {
      logic hold;
      logic last;
      logic div_more;
   } seq_status_type;

   function automatic ucode_type ucode_rom(step_type step);
      ucode_type w;
      unique case (step)
         ST_IDLE:     w = '{op: OP_ACCEPT,   cond: COND_NONE,     target: ST_IDLE};
         ST_X2_MUL:   w = '{op: OP_X2_MUL,   cond: COND_NONE,     target: ST_IDLE};
         ST_X2_RND:   w = '{op: OP_X2_RND,   cond: COND_NONE,     target: ST_IDLE};
         ST_EMIT:     w = '{op: OP_EMIT,     cond: COND_LAST,     target: ST_IDLE};
         ST_MUL:      w = '{op: OP_TERM_MUL, cond: COND_NONE,     target: ST_IDLE};
         ST_RND:      w = '{op: OP_TERM_RND, cond: COND_NONE,     target: ST_IDLE};
         ST_SCALE:    w = '{op: OP_SCALE,    cond: COND_NONE,     target: ST_IDLE};
         ST_DIV_LOAD: w = '{op: OP_DIV_LOAD, cond: COND_NONE,     target: ST_IDLE};
         ST_DIV:      w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: ST_DIV};
         ST_UPDATE:   w = '{op: OP_UPDATE,   cond: COND_ALWAYS,   target: ST_EMIT};
         default:     w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: ST_IDLE};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

>>> rtl/taylor_series_evaluator_unit.sv
// Top level of the Taylor series evaluator for sin, cos, exp and ln(1+x).
//
// An item on the req_ channel carries a function code and a Q1.28 argument.
// For each item the block returns num_terms results (clamped to 1..MAX_TERMS)
// on the rsp_ channel, one per series term, with the term index, the term, the
// saturating partial sum and a last flag on the final term. The csr_ channel
// writes num_terms; it is always ready and is meant to be written between
// items. A microcode sequencer drives one 32x32 multiplier and a restoring
// divider. After an accepted item the x-squared multiply and round steps run,
// then emit loads the first result. Each further term runs the multiply, round,
// scale, divider load, divide and update steps, then emit; the divider retires
// one quotient bit a cycle from a 40-bit dividend with the default MAX_TERMS
// of 32. The next item is accepted as soon as the last result sits in the
// output register. When rsp_stall is high while a result is valid, the result
// register holds and the sequencer waits at its emit step. Reset returns the
// sequencer to idle, drops rsp_valid and sets num_terms to 20.
`default_nettype none
module taylor_series_evaluator_unit
   import tse_pkg::*;
#(
   parameter int MAX_TERMS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [CMD_W-1:0]  req_command,
   input  wire logic [X_W-1:0]    req_x_value,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [TIDX_W-1:0] rsp_term_index,
   output      logic [Q_W-1:0]    rsp_term_value,
   output      logic [Q_W-1:0]    rsp_partial_sum,
   output      logic              rsp_last,
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   seq_ctrl_type   ctrl;
   seq_status_type status;

   tse_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   tse_datapath #(
      .MAX_TERMS (MAX_TERMS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_x_value     (req_x_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_term_index  (rsp_term_index),
      .rsp_term_value  (rsp_term_value),
      .rsp_partial_sum (rsp_partial_sum),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

endmodule
`default_nettype wire

>>> rtl/tse_divider.sv
// Restoring divider that produces one quotient bit per cycle while step is high.
`default_nettype none
module tse_divider
   import tse_pkg::*;
#(
   parameter int NUM_W = 40,
   parameter int DEN_W = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire logic             step,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output      logic [NUM_W-1:0] quotient,
   output      logic             more
);

   localparam int CNT_W = $clog2(NUM_W);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den};
      ge      = shifted >= {1'b0, den};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         rem_in = '0;
         quo_in = num;
         cnt_in = CNT_W'(NUM_W - 1);
      end else if (step) begin
         rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign more     = cnt_ff != '0;

   assert property (@(posedge clock) disable iff (reset) step |=> rem_ff < den)
      else $error("Divider remainder is not below the divisor.");

endmodule
`default_nettype wire

>>> rtl/tse_sequencer.sv
// Microcode sequencer: step counter, control word fetch and conditional jumps.
`default_nettype none
module tse_sequencer
   import tse_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire seq_status_type status,
   output      seq_ctrl_type   ctrl
);

   step_type  pc_ff, pc_in;
   ucode_type uword;
   logic      take;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      uword   = ucode_rom(pc_ff);
      ctrl.op = uword.op;
      unique case (uword.cond)
         COND_NONE:     take = 1'b0;
         COND_ALWAYS:   take = 1'b1;
         COND_LAST:     take = status.last;
         COND_DIV_MORE: take = status.div_more;
         default:       take = 1'b0;
      endcase
      if (status.hold) begin
         pc_in = pc_ff;
      end else if (take) begin
         pc_in = uword.target;
      end else begin
         pc_in = step_type'(pc_ff + 4'd1);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_EMIT && !status.hold && status.last) |=> pc_ff == ST_IDLE)
      else $error("Sequencer did not return to idle after the last term.");

   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_UPDATE) |=> pc_ff == ST_EMIT)
      else $error("Sequencer did not emit after a term update.");

endmodule
`default_nettype wire

>>> rtl/tse_datapath.sv
// Datapath: argument and term registers, multiplier, rounding, scaling and output register.
`default_nettype none
module tse_datapath
   import tse_pkg::*;
#(
   parameter int MAX_TERMS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire seq_ctrl_type        ctrl,
   output      seq_status_type      status,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [CMD_W-1:0]    req_command,
   input  wire logic [X_W-1:0]      req_x_value,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [TIDX_W-1:0]   rsp_term_index,
   output      logic [Q_W-1:0]      rsp_term_value,
   output      logic [Q_W-1:0]      rsp_partial_sum,
   output      logic                rsp_last,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [CSR_W-1:0]    csr_wdata
);

   localparam int IDX_W = $clog2(MAX_TERMS);
   localparam int NUM_W = RND_W + IDX_W + 1;
   localparam int DEN_W = 2 * IDX_W + 2;

   logic [CSR_W-1:0]         num_terms_ff, num_terms_in;
   cmd_type                  cmd_ff, cmd_in;
   logic signed [X_W-1:0]    x_ff, x_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [IDX_W-1:0]         last_idx_ff, last_idx_in;
   logic signed [Q_W-1:0]    term_ff, term_in;
   logic signed [Q_W-1:0]    sum_ff, sum_in;
   logic signed [Q_W-1:0]    x2_ff, x2_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [NUM_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [TIDX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [Q_W-1:0]           rsp_term_ff, rsp_term_in;
   logic [Q_W-1:0]           rsp_sum_ff, rsp_sum_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic signed [Q_W-1:0]    x_ext;
   logic signed [Q_W-1:0]    mul_a;
   logic signed [Q_W-1:0]    mul_b;
   logic signed [PROD_W-1:0] prod_raw;
   logic [PROD_W-1:0]        prod_mag;
   logic [PROD_W-1:0]        rnd_sum;
   logic [RND_W-1:0]         rnd_mag;
   logic [IDX_W:0]           scale;
   logic [NUM_W+IDX_W:0]     scaled;
   logic [IDX_W+1:0]         i2;
   logic [2*IDX_W+3:0]       den_wide;
   logic [7:0]               n_ext;
   logic [7:0]               n_clamp;
   logic [NUM_W-1:0]         div_num;
   logic [NUM_W-1:0]         div_quo;
   logic                     div_more;
   logic [NUM_W:0]           quo_signed;
   logic                     quo_fits;
   logic signed [Q_W-1:0]    new_term;
   logic signed [Q_W:0]      sum_wide;
   logic [IDX_W+TIDX_W-1:0]  idx_wide;
   logic                     is_last;
   logic                     accept;
   logic                     emit;
   logic                     hold;
   logic [Q_W-1:0]           term_init;

   tse_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .load     (ctrl.op == OP_DIV_LOAD),
      .step     (ctrl.op == OP_DIV_STEP),
      .num      (div_num),
      .den      (den_ff),
      .quotient (div_quo),
      .more     (div_more)
   );

   always_comb begin
      x_ext    = {{(Q_W - X_W){x_ff[X_W-1]}}, x_ff};
      is_last  = idx_ff == last_idx_ff;
      hold     = ((ctrl.op == OP_ACCEPT) && !req_valid) ||
                 ((ctrl.op == OP_EMIT) && rsp_valid_ff && rsp_stall);
      accept   = (ctrl.op == OP_ACCEPT) && req_valid;
      emit     = (ctrl.op == OP_EMIT) && !hold;

      if (ctrl.op == OP_X2_MUL) begin
         mul_a = x_ext;
         mul_b = x_ext;
      end else begin
         mul_a = (cmd_ff == CMD_SIN || cmd_ff == CMD_COS) ? x2_ff : x_ext;
         mul_b = term_ff;
      end
      prod_raw = mul_a * mul_b;

      prod_mag = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      rnd_sum  = prod_mag + HALF_Q;
      rnd_mag  = rnd_sum[FRAC_BITS+RND_W-1:FRAC_BITS];

      scale    = (cmd_ff == CMD_LN) ? ({1'b0, idx_ff} + (IDX_W+1)'(1)) : (IDX_W+1)'(1);
      scaled   = mag_ff * scale;

      i2 = {1'b0, idx_ff, 1'b0};
      unique case (cmd_ff)
         CMD_SIN: den_wide = (i2 + (IDX_W+2)'(3)) * (i2 + (IDX_W+2)'(2));
         CMD_COS: den_wide = (i2 + (IDX_W+2)'(1)) * (i2 + (IDX_W+2)'(2));
         CMD_EXP: den_wide = (2*IDX_W+4)'(idx_ff) + (2*IDX_W+4)'(1);
         CMD_LN:  den_wide = (2*IDX_W+4)'(idx_ff) + (2*IDX_W+4)'(2);
         default: den_wide = (2*IDX_W+4)'(1);
      endcase

      div_num = mag_ff + NUM_W'(den_ff >> 1);

      quo_signed = neg_ff ? -{1'b0, div_quo} : {1'b0, div_quo};
      quo_fits   = quo_signed[NUM_W:Q_W-1] == {(NUM_W - Q_W + 2){quo_signed[NUM_W]}};
      if (quo_fits) begin
         new_term = quo_signed[Q_W-1:0];
      end else begin
         new_term = quo_signed[NUM_W] ? Q_MIN : Q_MAX;
      end
      sum_wide = {sum_ff[Q_W-1], sum_ff} + {new_term[Q_W-1], new_term};

      n_ext = {{(8 - CSR_W){1'b0}}, num_terms_ff};
      if (n_ext == 8'd0) begin
         n_clamp = 8'd1;
      end else if (n_ext > 8'(MAX_TERMS)) begin
         n_clamp = 8'(MAX_TERMS);
      end else begin
         n_clamp = n_ext;
      end

      term_init = (cmd_type'(req_command) == CMD_SIN || cmd_type'(req_command) == CMD_LN) ?
                  {{(Q_W - X_W){req_x_value[X_W-1]}}, req_x_value} : ONE_Q;
      idx_wide  = {{TIDX_W{1'b0}}, idx_ff};

      num_terms_in = (csr_valid && csr_ready) ? csr_wdata : num_terms_ff;
      cmd_in       = cmd_ff;
      x_in         = x_ff;
      idx_in       = idx_ff;
      last_idx_in  = last_idx_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      x2_in        = x2_ff;
      prod_in      = prod_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      den_in       = den_ff;
      rsp_index_in = rsp_index_ff;
      rsp_term_in  = rsp_term_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (ctrl.op)
         OP_ACCEPT: begin
            if (accept) begin
               cmd_in      = cmd_type'(req_command);
               x_in        = req_x_value;
               idx_in      = '0;
               last_idx_in = IDX_W'(n_clamp - 8'd1);
               term_in     = term_init;
               sum_in      = term_init;
            end
         end
         OP_X2_MUL, OP_TERM_MUL: begin
            prod_in = prod_raw;
            den_in  = den_wide[DEN_W-1:0];
         end
         OP_X2_RND: begin
            x2_in = Q_W'(rnd_mag);
         end
         OP_TERM_RND: begin
            mag_in = NUM_W'(rnd_mag);
            neg_in = prod_ff[PROD_W-1] ^ (cmd_ff != CMD_EXP);
         end
         OP_SCALE: begin
            mag_in = scaled[NUM_W-1:0];
         end
         OP_UPDATE: begin
            term_in = new_term;
            if (sum_wide[Q_W] != sum_wide[Q_W-1]) begin
               sum_in = sum_wide[Q_W] ? Q_MIN : Q_MAX;
            end else begin
               sum_in = sum_wide[Q_W-1:0];
            end
            idx_in = idx_ff + IDX_W'(1);
         end
         OP_EMIT: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = idx_wide[TIDX_W-1:0];
               rsp_term_in  = term_ff;
               rsp_sum_in   = sum_ff;
               rsp_last_in  = is_last;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_terms_ff <= NUM_TERMS_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_terms_ff <= num_terms_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      x_ff         <= x_in;
      idx_ff       <= idx_in;
      last_idx_ff  <= last_idx_in;
      term_ff      <= term_in;
      sum_ff       <= sum_in;
      x2_ff        <= x2_in;
      prod_ff      <= prod_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      den_ff       <= den_in;
      rsp_index_ff <= rsp_index_in;
      rsp_term_ff  <= rsp_term_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status = '{hold: hold, last: is_last, div_more: div_more};

   assign req_stall       = ctrl.op != OP_ACCEPT;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_term_index  = rsp_index_ff;
   assign rsp_term_value  = rsp_term_ff;
   assign rsp_partial_sum = rsp_sum_ff;
   assign rsp_last        = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_UPDATE) |-> !is_last)
      else $error("Term update past the last term of the item.");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.op == OP_EMIT))
      else $error("Result register loaded outside an emit step.");

endmodule
`default_nettype wire

>>> test/taylor_series_checker.sv
// Checker for the Taylor series evaluator: predicts every term result and compares it.
module taylor_series_checker
   import tse_pkg::*;
#(
   parameter int MAX_TERMS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [X_W-1:0]    req_x_value,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [TIDX_W-1:0] rsp_term_index,
   input  logic [Q_W-1:0]    rsp_term_value,
   input  logic [Q_W-1:0]    rsp_partial_sum,
   input  logic              rsp_last,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_wdata,
   output int                terms_due,
   output int                mismatch_count
);

   localparam longint Q_TOP    = 64'sd2147483647;
   localparam longint Q_BOTTOM = -64'sd2147483648;

   typedef struct packed {
      logic [TIDX_W-1:0] term_index;
      logic [Q_W-1:0]    term_value;
      logic [Q_W-1:0]    partial_sum;
      logic              last;
   } term_result_t;

   term_result_t     expected_terms[$];
   logic [CSR_W-1:0] num_terms_setting;

   initial begin
      terms_due = 0;
      mismatch_count = 0;
      num_terms_setting = NUM_TERMS_RST;
   end

   function automatic longint round_product(longint a, longint b);
      longint          p;
      longint unsigned m;
      p = a * b;
      m = (p < 0) ? -p : p;
      m = (m + HALF_Q) >> FRAC_BITS;
      return (p < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint divide_rounded(longint v, longint unsigned d);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      m = (m + d / 2) / d;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clamp_q(longint v);
      if (v > Q_TOP) return Q_TOP;
      if (v < Q_BOTTOM) return Q_BOTTOM;
      return v;
   endfunction

   function automatic void expand_series(cmd_type cmd, logic [X_W-1:0] x_bits);
      longint       x;
      longint       x2;
      longint       term;
      longint       sum;
      int           n;
      term_result_t r;
      x = $signed(x_bits);
      x2 = round_product(x, x);
      n = num_terms_setting;
      if (n < 1) n = 1;
      if (n > MAX_TERMS) n = MAX_TERMS;
      term = (cmd == CMD_SIN || cmd == CMD_LN) ? x : longint'(ONE_Q);
      term = clamp_q(term);
      sum = term;
      for (int i = 0; i < n; i++) begin
         r.term_index = i[TIDX_W-1:0];
         r.term_value = term[Q_W-1:0];
         r.partial_sum = sum[Q_W-1:0];
         r.last = (i == n - 1);
         expected_terms.push_back(r);
         if (i == n - 1) break;
         case (cmd)
            CMD_SIN: term = -divide_rounded(round_product(x2, term), (2*i + 3) * (2*i + 2));
            CMD_COS: term = -divide_rounded(round_product(x2, term), (2*i + 1) * (2*i + 2));
            CMD_EXP: term = divide_rounded(round_product(x, term), i + 1);
            default: term = -divide_rounded(round_product(x, term) * (i + 1), i + 2);
         endcase
         term = clamp_q(term);
         sum = clamp_q(sum + term);
      end
   endfunction

   always @(posedge clock) begin
      term_result_t want;
      term_result_t got;
      if (reset) begin
         num_terms_setting = NUM_TERMS_RST;
         expected_terms.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_term_index, rsp_term_value, rsp_partial_sum, rsp_last};
            if (expected_terms.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result: expected none, got index %0d term %0d sum %0d last %0d",
                        $time, got.term_index, $signed(got.term_value),
                        $signed(got.partial_sum), got.last);
            end else begin
               want = expected_terms.pop_front();
               if (got.term_index !== want.term_index || got.term_value !== want.term_value ||
                   got.partial_sum !== want.partial_sum || got.last !== want.last) begin
                  mismatch_count++;
                  $display("%0t: term mismatch: expected index %0d term %0d sum %0d last %0d, %s",
                           $time, want.term_index, $signed(want.term_value),
                           $signed(want.partial_sum), want.last,
                           $sformatf("got index %0d term %0d sum %0d last %0d",
                                     got.term_index, $signed(got.term_value),
                                     $signed(got.partial_sum), got.last));
               end
            end
         end
         if (req_valid && !req_stall)
            expand_series(cmd_type'(req_command), req_x_value);
         if (csr_valid && csr_ready)
            num_terms_setting = csr_wdata;
      end
      terms_due = expected_terms.size();
   end

endmodule

>>> test/tb_taylor_series_evaluator_unit.sv
// Testbench top for the Taylor series evaluator: stimulus, idling, watchdog and verdict.
module tb_taylor_series_evaluator_unit;
   import tse_pkg::*;

   localparam int RANDOM_ITEMS   = 446;
   localparam int CALM_ITEMS     = 60;
   localparam int WATCHDOG_LIMIT = 3000;

   localparam logic [X_W-1:0] X_ONE     = 30'h1000_0000;
   localparam logic [X_W-1:0] X_NEG_ONE = 30'h3000_0000;
   localparam logic [X_W-1:0] X_MAX     = 30'h1FFF_FFFF;
   localparam logic [X_W-1:0] X_MIN     = 30'h2000_0000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [CMD_W-1:0]  req_command = '0;
   logic [X_W-1:0]    req_x_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [TIDX_W-1:0] rsp_term_index;
   logic [Q_W-1:0]    rsp_term_value;
   logic [Q_W-1:0]    rsp_partial_sum;
   logic              rsp_last;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_wdata = '0;

   int                terms_due;
   int                mismatch_count;
   logic              calm = 1'b0;
   int                stall_burst = 0;
   int                quiet_cycles = 0;

   always #10 clock = ~clock;

   taylor_series_evaluator_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_x_value     (req_x_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_term_index  (rsp_term_index),
      .rsp_term_value  (rsp_term_value),
      .rsp_partial_sum (rsp_partial_sum),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   taylor_series_checker term_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_x_value     (req_x_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_term_index  (rsp_term_index),
      .rsp_term_value  (rsp_term_value),
      .rsp_partial_sum (rsp_partial_sum),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .terms_due       (terms_due),
      .mismatch_count  (mismatch_count)
   );

   always @(negedge clock) begin
      if (calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_burst > 0) begin
         stall_burst <= stall_burst - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_burst <= $urandom_range(0, 40);
      end else begin
         rsp_stall <= 1'b1;
         stall_burst <= $urandom_range(0, 5);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [X_W-1:0] pick_argument();
      int v;
      case ($urandom_range(0, 9))
         0: return X_W'($urandom);
         1: begin
            case ($urandom_range(0, 4))
               0: return X_ONE;
               1: return X_NEG_ONE;
               2: return X_MAX;
               3: return X_MIN;
               default: return '0;
            endcase
         end
         default: begin
            v = int'($urandom_range(0, 536870912)) - 268435456;
            return X_W'(v);
         end
      endcase
   endfunction

   task automatic program_terms(input logic [CSR_W-1:0] count);
      csr_valid <= 1'b1;
      csr_wdata <= count;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_request(input cmd_type cmd, input logic [X_W-1:0] x);
      int gap;
      if (!calm && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_x_value <= x;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (terms_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      int sent;
      int setting;
      int effective;
      int batch;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int c = 0; c < 4; c++) begin
         send_request(cmd_type'(c), '0);
         send_request(cmd_type'(c), X_ONE);
         send_request(cmd_type'(c), X_NEG_ONE);
      end
      wait_for_idle();

      program_terms(6'd32);
      send_request(CMD_LN, X_MAX);
      send_request(CMD_LN, X_MIN);
      send_request(CMD_EXP, X_MAX);
      send_request(CMD_EXP, X_MIN);
      send_request(CMD_SIN, X_MIN);
      send_request(CMD_COS, X_MAX);
      wait_for_idle();

      program_terms(6'd0);
      send_request(CMD_SIN, pick_argument());
      send_request(CMD_COS, pick_argument());
      send_request(CMD_EXP, pick_argument());
      send_request(CMD_LN, pick_argument());
      wait_for_idle();

      program_terms(6'd63);
      send_request(CMD_LN, X_MAX);
      wait_for_idle();
      program_terms(6'd33);
      send_request(CMD_COS, X_ONE);
      wait_for_idle();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin
               case ($urandom_range(0, 4))
                  0: setting = 0;
                  1: setting = 1;
                  2: setting = 32;
                  3: setting = 33;
                  default: setting = 63;
               endcase
            end
            1: setting = $urandom_range(0, 63);
            default: setting = $urandom_range(1, 8);
         endcase
         effective = (setting < 1) ? 1 : (setting > 32) ? 32 : setting;
         batch = (effective > 8) ? $urandom_range(2, 4) : $urandom_range(15, 40);
         if (batch > RANDOM_ITEMS - sent) batch = RANDOM_ITEMS - sent;
         if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
         program_terms(CSR_W'(setting));
         for (int k = 0; k < batch; k++)
            send_request(cmd_type'($urandom_range(0, 3)), pick_argument());
         sent += batch;
         wait_for_idle();
      end

      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && terms_due == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
rtl/tse_pkg.sv
rtl/tse_divider.sv
rtl/tse_sequencer.sv
rtl/tse_datapath.sv
rtl/taylor_series_evaluator_unit.sv
test/taylor_series_checker.sv
test/tb_taylor_series_evaluator_unit.sv
